FILE: rtl/map_stack_linear_interpolator_macros.svh
// map_stack_linear_interpolator_macros.svh
// Assertion macros for the map stack interpolator; ASSERT_OFF drops them all.
// Needs nothing else; include it where the assertions sit.
`ifndef MAP_STACK_LINEAR_INTERPOLATOR_MACROS_SVH
`define MAP_STACK_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define MSLIN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define MSLIN_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MSLIN_ASSERT(label, clk, rst_n, prop, msg)
`define MSLIN_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/mslin_pkg.sv
`timescale 1ns / 1ps
// mslin_pkg: widths, sizes, codes and divider handshake types of the map stack interpolator.
// No dependencies; compile first.
package mslin_pkg;

    localparam int NUM_ANGLES  = 16;
    localparam int MAP_ROWS    = 8;
    localparam int MAP_COLS    = 8;
    localparam int CELL_SLOTS  = 64;
    localparam int RAW_CELLS   = MAP_ROWS * MAP_COLS;
    localparam int MAP_CELLS   = (RAW_CELLS > CELL_SLOTS) ? CELL_SLOTS : RAW_CELLS;

    localparam int ACT_W       = 2;
    localparam int ENTRY_W     = 4;
    localparam int CELL_W      = 6;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 5;
    localparam int FRAC_W      = 16;
    localparam int DIV_CNT_W   = $clog2(FRAC_W);
    localparam int STORE_DEPTH = NUM_ANGLES * CELL_SLOTS;
    localparam int STORE_AW    = ENTRY_W + CELL_W;
    localparam int PROD_W      = VAL_W + FRAC_W + 2;

    typedef logic [ACT_W-1:0] t_action;

    localparam t_action ACT_WR_ANGLE = 2'd0;
    localparam t_action ACT_WR_CELL  = 2'd1;
    localparam t_action ACT_QUERY    = 2'd2;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(MAP_CELLS - 1);

    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  num;
        logic [VAL_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: rtl/mslin_ifs.sv
`timescale 1ns / 1ps
// mslin_ifs: request and result channel interfaces of the map stack interpolator.
// Depends on mslin_pkg.
interface mslin_req_if import mslin_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_action                  action;
    logic [ENTRY_W-1:0]       entry_index;
    logic [CELL_W-1:0]        cell_index;
    logic signed [VAL_W-1:0]  load_value;
    logic signed [VAL_W-1:0]  heading;

    modport source (output valid, action, entry_index, cell_index, load_value, heading,
                    input ready);
    modport sink   (input valid, action, entry_index, cell_index, load_value, heading,
                    output ready);
endinterface

interface mslin_res_if import mslin_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     status;
    logic [CELL_W-1:0]        cell_res;
    logic signed [VAL_W-1:0]  speed;
    logic                     last;

    modport source (output valid, status, cell_res, speed, last, input ready);
    modport sink   (input valid, status, cell_res, speed, last, output ready);
endinterface

FILE: rtl/map_stack_linear_interpolator.sv
`timescale 1ns / 1ps
// map_stack_linear_interpolator: angle table, speed map store and query sequencer.
// Depends on mslin_pkg, mslin_ifs, mslin_div and the assertion macro header.
//
// Usage:
//  - i_req carries requests: action 0 writes an angle entry, action 1 writes one map
//    cell, action 2 queries a heading; action 3 is dropped. Loads give no result.
//    i_req.ready is high only while the block is idle.
//  - o_res carries one result per map cell, cell 0 first, last set on the final one.
//    A query with no entries in use gives a single result with status 1.
//  - i_cfg_we/i_cfg_wdata write entries_in_use (values above 16 act as 16); write it
//    only while idle.
//  - Query sequence: table lookup and first cell read, then a scan of the angles in
//    turn (up to 15) and a divider run (load, 16 bits, done) when the heading falls
//    between two angles, then multiply, add and hand off for each of the 64 cells.
//    The per-cell chain sets the pace.
//  - The result sits in an output register; a stalled receiver holds the sequencer
//    in place, and the next cell is prefetched while the current one waits to be taken.
//  - Reset (synchronous, active low) clears the sequencer and entries_in_use; the
//    table and map memories keep whatever they hold and must be loaded before use.
`include "map_stack_linear_interpolator_macros.svh"
module map_stack_linear_interpolator import mslin_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    mslin_req_if.sink          i_req,
    mslin_res_if.source        o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LASTA,
        S_SCAN,
        S_DIV,
        S_RD,
        S_MUL,
        S_ADD,
        S_OUT,
        S_ERR
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_entries;
    logic [CNT_W-1:0]          r_n;
    logic signed [VAL_W-1:0]   r_heading;
    logic signed [VAL_W-1:0]   r_a_first;
    logic signed [VAL_W-1:0]   r_prev;
    logic [ENTRY_W-1:0]        r_idx;
    logic [ENTRY_W-1:0]        r_lo;
    logic [ENTRY_W-1:0]        r_hi;
    logic [FRAC_W-1:0]         r_t;
    logic [CELL_W-1:0]         r_cell;
    logic signed [VAL_W-1:0]   r_v0;
    logic signed [PROD_W-1:0]  r_prod;
    t_div_req                  r_div_req;

    logic                      r_status;
    logic [CELL_W-1:0]         r_cell_res;
    logic signed [VAL_W-1:0]   r_speed;
    logic                      r_last;

    // memories
    logic [VAL_W-1:0]          angle_mem [NUM_ANGLES];
    logic [VAL_W-1:0]          speed_mem [STORE_DEPTH];
    logic signed [VAL_W-1:0]   r_ang_rd;
    logic signed [VAL_W-1:0]   r_sp_lo;
    logic signed [VAL_W-1:0]   r_sp_hi;

    logic                      accept;
    logic [CNT_W-1:0]          sat_n;
    logic [ENTRY_W-1:0]        last_entry;
    logic [ENTRY_W-1:0]        ang_raddr;
    logic [CELL_W-1:0]         cell_addr;
    logic                      scan_hit;
    logic                      span_ok;
    logic signed [VAL_W:0]     cell_diff;
    t_div_rsp                  div_rsp;

    assign accept     = i_req.valid && i_req.ready;
    assign sat_n      = (r_entries > CNT_W'(NUM_ANGLES)) ? CNT_W'(NUM_ANGLES) : r_entries;
    assign last_entry = ENTRY_W'(r_n - 1'b1);

    // angle read address: first entry, then last in use, then walk from entry 1
    always_comb begin
        unique case (r_state)
            S_FIRST: ang_raddr = last_entry;
            S_LASTA: ang_raddr = ENTRY_W'(1);
            S_SCAN:  ang_raddr = r_idx + 1'b1;
            default: ang_raddr = '0;
        endcase
    end

    // prefetch the next cell while the current one is being finished or held
    assign cell_addr = ((r_state == S_ADD) || (r_state == S_OUT)) ? (r_cell + 1'b1) : r_cell;

    assign scan_hit  = (r_ang_rd > r_heading) || (r_idx == last_entry);
    assign span_ok   = (r_ang_rd > r_prev) && (r_heading >= r_prev);
    assign cell_diff = (VAL_W+1)'(r_sp_hi) - (VAL_W+1)'(r_sp_lo);

    always_ff @(posedge i_clk) begin
        if (accept && (i_req.action == ACT_WR_ANGLE)
            && ({1'b0, i_req.entry_index} < (ENTRY_W+1)'(NUM_ANGLES))) begin
            angle_mem[i_req.entry_index] <= i_req.load_value;
        end
        r_ang_rd <= angle_mem[ang_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_req.action == ACT_WR_CELL)
            && ({1'b0, i_req.entry_index} < (ENTRY_W+1)'(NUM_ANGLES))
            && ({1'b0, i_req.cell_index} < (CELL_W+1)'(MAP_CELLS))) begin
            speed_mem[{i_req.entry_index, i_req.cell_index}] <= i_req.load_value;
        end
        r_sp_lo <= speed_mem[STORE_AW'({r_lo, cell_addr})];
        r_sp_hi <= speed_mem[STORE_AW'({r_hi, cell_addr})];
    end

    mslin_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_entries       <= '0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_req.action == ACT_QUERY)) begin
                        r_heading <= i_req.heading;
                        r_n       <= sat_n;
                        if (sat_n == '0) begin
                            r_status   <= STAT_EMPTY;
                            r_cell_res <= '0;
                            r_speed    <= '0;
                            r_last     <= 1'b1;
                            r_state    <= S_ERR;
                        end else begin
                            r_state <= S_FIRST;
                        end
                    end
                end
                S_FIRST: begin
                    r_a_first <= r_ang_rd;
                    r_state   <= S_LASTA;
                end
                S_LASTA: begin
                    // outside the table: send one map unchanged; else scan for the enclosing pair
                    r_t    <= '0;
                    r_cell <= '0;
                    if (r_heading <= r_a_first) begin
                        r_lo    <= '0;
                        r_hi    <= '0;
                        r_state <= S_RD;
                    end else if (r_heading >= r_ang_rd) begin
                        r_lo    <= last_entry;
                        r_hi    <= last_entry;
                        r_state <= S_RD;
                    end else begin
                        r_prev  <= r_a_first;
                        r_idx   <= ENTRY_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_lo <= r_idx - 1'b1;
                        r_hi <= r_idx;
                        if (span_ok) begin
                            r_div_req.start <= 1'b1;
                            r_div_req.num   <= VAL_W'(r_heading - r_prev);
                            r_div_req.den   <= VAL_W'(r_ang_rd - r_prev);
                            r_state         <= S_DIV;
                        end else begin
                            r_t     <= '0;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_prev <= r_ang_rd;
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_t     <= div_rsp.quot;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // cell read issued this cycle; data lands next cycle
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // v0*65536 + t*(v1-v0): keep only the weighted difference here
                    r_v0    <= r_sp_lo;
                    r_prod  <= PROD_W'($signed({1'b0, r_t}) * cell_diff);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_status   <= STAT_OK;
                    r_cell_res <= r_cell;
                    r_speed    <= r_v0 + r_prod[VAL_W+FRAC_W-1:FRAC_W];
                    r_last     <= (r_cell == LAST_CELL);
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cell  <= r_cell + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_ERR: begin
                    if (o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_res.valid    = (r_state == S_OUT) || (r_state == S_ERR);
    assign o_res.status   = r_status;
    assign o_res.cell_res = r_cell_res;
    assign o_res.speed    = r_speed;
    assign o_res.last     = r_last;

    `MSLIN_NEVER(a_ready_excl, i_clk, i_rst_n, i_req.ready && o_res.valid, "request taken while a result is pending")
    `MSLIN_ASSERT(a_last_idle, i_clk, i_rst_n, (o_res.valid && o_res.ready && o_res.last) |=> i_req.ready, "not idle after final result")
    `MSLIN_ASSERT(a_mid_busy, i_clk, i_rst_n, (o_res.valid && o_res.ready && !o_res.last) |=> !i_req.ready, "query ended before its final cell")
    `MSLIN_ASSERT(a_err_shape, i_clk, i_rst_n, (o_res.valid && o_res.status == STAT_EMPTY) |-> (o_res.last && o_res.cell_res == '0 && o_res.speed == '0), "malformed empty-table result")
    `MSLIN_ASSERT(a_last_cell, i_clk, i_rst_n, (o_res.valid && o_res.status == STAT_OK) |-> (o_res.last == (o_res.cell_res == LAST_CELL)), "last flag off the final cell")

endmodule

FILE: rtl/mslin_div.sv
`timescale 1ns / 1ps
// mslin_div: restoring divider, one quotient bit per cycle, for the Q0.16 blend weight.
// Depends on mslin_pkg; needs num < den so the quotient fits FRAC_W bits.
module mslin_div import mslin_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_rem;
    logic [VAL_W-1:0]     r_den;
    logic [FRAC_W-1:0]    r_quot;

    logic [VAL_W:0]       rem2;
    logic [VAL_W:0]       rem_sub;
    logic                 take;

    always_comb begin
        rem2    = {r_rem, 1'b0};
        rem_sub = rem2 - {1'b0, r_den};
        take    = (rem2 >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                // shift in one bit, subtract when it fits
                r_rem  <= take ? rem_sub[VAL_W-1:0] : rem2[VAL_W-1:0];
                r_quot <= {r_quot[FRAC_W-2:0], take};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
